>>> sv/pqwt_pkg.sv
package pqwt_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TIME_W   = 12;
  localparam int PRIO_W   = 8;
  localparam int POS_W    = 5;
  localparam int WAIT_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] service_time;
    logic [PRIO_W-1:0] priority_req;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]    position;
    logic [WAIT_W-1:0]   wait_total;
    logic [TIME_W-1:0]   popped_time;
    logic [TIME_W-1:0]   front_time;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] stime;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

>>> sv/pqwt_ram.sv
module pqwt_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/priority_queue_with_wait_time_core.sv
// Sorted service queue of up to QUEUE_DEPTH (service time, priority) entries,
// lowest priority number at the front, equal priorities in arrival order.
// Issue a command by raising start while busy is low; the transfer happens on
// that edge. Exactly one result follows, shown for one cycle with done high;
// the receiver cannot hold it, so capture it when done is seen. A new command
// may be issued in the cycle that done is high. A refused push or pop, and a
// pop that leaves the queue empty, answer straight from idle; any other pop
// does one RAM read to fetch the new front. A push into an empty queue writes
// the new entry at once; otherwise it walks the queue from the back, with a
// RAM read, then a compare and move, per entry examined, then writes the new
// entry and gives the result. The entry RAM is a ring with a head pointer, so
// a pop never moves data; the single read port of that RAM sets the pace of
// the push walk.
module priority_queue_with_wait_time_core #(
  parameter int QUEUE_DEPTH = pqwt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pqwt_pkg::cmd_t    cmd,
  output logic              done,
  output pqwt_pkg::result_t result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (CW > pqwt_pkg::POS_W) ? CW : pqwt_pkg::POS_W;
  localparam int TW = $clog2(QUEUE_DEPTH * (2 ** pqwt_pkg::TIME_W));
  localparam int EW = $bits(pqwt_pkg::entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_WR,
    S_FRONT_RD,
    S_FRONT_LD
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   head;     // ring position of the front
  logic [CW-1:0]                   count;
  logic [TW-1:0]                   total;    // sum of all stored service times
  logic [AW-1:0]                   idx;      // logical index under test
  logic [AW-1:0]                   place;    // logical slot of the new entry
  logic [TW-1:0]                   shifted;  // times of entries moved behind it
  logic [pqwt_pkg::TIME_W-1:0]     front;
  pqwt_pkg::cmd_t                  cur;

  logic                            we;
  logic [AW-1:0]                   wr_addr;
  logic [AW-1:0]                   rd_addr;
  logic [EW-1:0]                   wr_data;
  logic [EW-1:0]                   rd_data;
  pqwt_pkg::entry_t                rd_entry;
  pqwt_pkg::entry_t                new_entry;
  logic [31:0]                     wait_sum;
  logic [pqwt_pkg::WAIT_W-1:0]     wait_sat;
  logic [PW-1:0]                   pos_full;

  // Map a logical index onto the ring: head + offset, wrapped at the depth.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, ofs};
    if (s >= (AW + 1)'(QUEUE_DEPTH)) begin
      s = s - (AW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign busy      = (state != S_IDLE);
  assign rd_entry  = pqwt_pkg::entry_t'(rd_data);
  assign new_entry = '{stime: cur.service_time, prio: cur.priority_req};

  // Wait = everything stored, minus what sits behind the new entry, plus its own.
  assign wait_sum = 32'(total) - 32'(shifted) + 32'(cur.service_time);
  assign wait_sat = (wait_sum > 32'(pqwt_pkg::WAIT_MAX)) ? pqwt_pkg::WAIT_MAX
                                                        : pqwt_pkg::WAIT_W'(wait_sum);
  assign pos_full = PW'(place) + PW'(1);

  // RAM port control: the walk reads one entry and, when it must yield,
  // moves it one slot back; the insert writes the new entry; a pop reads the new front.
  always_comb begin
    rd_addr = phys(head, idx);
    we      = 1'b0;
    wr_addr = phys(head, idx + AW'(1));
    wr_data = rd_data;
    case (state)
      S_SCAN_CMP: begin
        we = (rd_entry.prio > cur.priority_req);
      end
      S_INS_WR: begin
        we      = 1'b1;
        wr_addr = phys(head, place);
        wr_data = EW'(new_entry);
      end
      S_FRONT_RD: begin
        rd_addr = head;
      end
      default: begin
      end
    endcase
  end

  pqwt_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur     <= cmd;
            shifted <= '0;
            result  <= '0;
            if (cmd.op == pqwt_pkg::OP_PUSH) begin
              if (count == CW'(QUEUE_DEPTH)) begin
                // Refuse: queue full, nothing changes.
                done               <= 1'b1;
                result.status      <= pqwt_pkg::ST_FULL;
                result.front_time  <= front;
                result.is_empty    <= 1'b0;
              end else if (count == '0) begin
                place <= '0;
                state <= S_INS_WR;
              end else begin
                // Walk from the last entry toward the front.
                idx   <= AW'(count - CW'(1));
                state <= S_SCAN_RD;
              end
            end else begin
              if (count == '0) begin
                // Refuse: nothing to pop.
                done            <= 1'b1;
                result.status   <= pqwt_pkg::ST_EMPTY;
                result.is_empty <= 1'b1;
              end else begin
                result.popped_time <= front;
                total <= total - TW'(front);
                head  <= phys(head, AW'(1));
                count <= count - CW'(1);
                if (count == CW'(1)) begin
                  done            <= 1'b1;
                  result.is_empty <= 1'b1;
                end else begin
                  state <= S_FRONT_RD;
                end
              end
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (rd_entry.prio > cur.priority_req) begin
            // Entry yields: it was moved back one slot this cycle.
            shifted <= shifted + TW'(rd_entry.stime);
            if (idx == '0) begin
              place <= '0;
              state <= S_INS_WR;
            end else begin
              idx   <= idx - AW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            place <= idx + AW'(1);
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          count <= count + CW'(1);
          total <= total + TW'(cur.service_time);
          if (place == '0) begin
            front             <= cur.service_time;
            result.front_time <= cur.service_time;
          end else begin
            result.front_time <= front;
          end
          result.position   <= pos_full[pqwt_pkg::POS_W-1:0];
          result.wait_total <= wait_sat;
          result.is_empty   <= 1'b0;
          result.status     <= pqwt_pkg::ST_OK;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        S_FRONT_RD: begin
          state <= S_FRONT_LD;
        end
        S_FRONT_LD: begin
          // Latch the new front after a pop.
          front             <= rd_entry.stime;
          result.front_time <= rd_entry.stime;
          result.is_empty   <= 1'b0;
          done              <= 1'b1;
          state             <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/pqwt_checker.sv
module pqwt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input pqwt_pkg::result_t result
);

  // A result always ends the command: the block is free when it is shown.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // An accepted command either keeps the block working or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command dropped");

  // A result needs a command behind it.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without command");

  // A placed push reports ok, a non-empty queue and no popped time.
  a_push_result: assert property (@(posedge clk) disable iff (rst)
    (done && (result.position != '0)) |->
      ((result.status == pqwt_pkg::ST_OK) && !result.is_empty &&
       (result.popped_time == '0)))
    else $error("push result inconsistent");

  // Refusals change nothing and report no position, wait time or popped time.
  a_refusal: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != pqwt_pkg::ST_OK)) |->
      ((result.position == '0) && (result.wait_total == '0) &&
       (result.popped_time == '0)))
    else $error("refusal carries data");

endmodule

bind priority_queue_with_wait_time_core pqwt_checker u_pqwt_checker (.*);

>>> bench/pqwt_tb_pkg.sv
package pqwt_tb_pkg;
  import pqwt_pkg::*;

  // Tracks the sorted service queue alongside the block and holds the
  // results it must produce, oldest first.
  class service_queue_tracker;
    int      depth;
    entry_t  slots[$];
    result_t expected_results[$];
    int      errors;
    int      checked;
    int      pushes;
    int      pops;
    int      full_refusals;
    int      empty_pops;
    int      max_fill;
    int unsigned max_wait;

    function new(int depth_i);
      depth = depth_i;
      errors = 0;
      checked = 0;
      pushes = 0;
      pops = 0;
      full_refusals = 0;
      empty_pops = 0;
      max_fill = 0;
      max_wait = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_command(cmd_t c);
      result_t     r;
      entry_t      e;
      int          place;
      int unsigned acc;
      r = '0;
      r.status = ST_OK;
      if (c.op == OP_PUSH) begin
        pushes++;
        if (slots.size() >= depth) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          place = 0;
          acc = 0;
          // new entry goes behind every entry of lower or equal number
          while (place < slots.size() && slots[place].prio <= c.priority_req) begin
            acc += slots[place].stime;
            if (acc > WAIT_MAX) acc = WAIT_MAX;
            place++;
          end
          acc += c.service_time;
          if (acc > WAIT_MAX) acc = WAIT_MAX;
          e.stime = c.service_time;
          e.prio = c.priority_req;
          slots.insert(place, e);
          r.position = POS_W'(place + 1);
          r.wait_total = WAIT_W'(acc);
          if (acc > max_wait) max_wait = acc;
          if (slots.size() > max_fill) max_fill = slots.size();
        end
      end else begin
        pops++;
        if (slots.size() == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          e = slots.pop_front();
          r.popped_time = e.stime;
        end
      end
      r.is_empty = (slots.size() == 0);
      r.front_time = r.is_empty ? '0 : slots[0].stime;
      expected_results.push_back(r);
    endfunction

    function void field_error(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    endfunction

    // Compare one delivered result with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %p", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.position !== want.position)
        field_error("position", want.position, got.position);
      if (got.wait_total !== want.wait_total)
        field_error("wait_total", want.wait_total, got.wait_total);
      if (got.popped_time !== want.popped_time)
        field_error("popped_time", want.popped_time, got.popped_time);
      if (got.front_time !== want.front_time)
        field_error("front_time", want.front_time, got.front_time);
      if (got.is_empty !== want.is_empty)
        field_error("is_empty", want.is_empty, got.is_empty);
      if (got.status !== want.status)
        field_error("status", want.status, got.status);
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
module tb_top;
  import pqwt_pkg::*;
  import pqwt_tb_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  // longest command: walk the whole queue, plus the write
  localparam int MAX_LAT    = 2 * DEPTH + 4;
  localparam int CYCLE_CAP  = 1000000;
  localparam int RAND_ITEMS = 1530;
  localparam int PHASES     = 12;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  service_queue_tracker sb;
  int cycles;

  priority_queue_with_wait_time_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Results show for one cycle only; capture every strobe.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic cmd_t make_cmd(logic op, int stime, int prio);
    cmd_t c;
    c.op = op;
    c.service_time = TIME_W'(stime);
    c.priority_req = PRIO_W'(prio);
    return c;
  endfunction

  // Random command; push_pct biases the fill level, prio_hi narrows the
  // priority range so ties show up often.
  function automatic cmd_t random_cmd(int push_pct, int prio_hi);
    cmd_t c;
    c.op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
    case ($urandom_range(7))
      0:       c.service_time = '0;
      1:       c.service_time = '1;
      default: c.service_time = TIME_W'($urandom);
    endcase
    if ($urandom_range(15) == 0)
      c.priority_req = '1;
    else
      c.priority_req = PRIO_W'($urandom_range(prio_hi));
    return c;
  endfunction

  // Raise start and hold the command until the block takes it. The caller
  // drives the next value of start, so it changes once per edge.
  task automatic send_cmd(cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off new commands until every result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_pct;
    int push_pct;
    int prio_hi;
    int per_phase;
    sb = new(DEPTH);
    cycles = 0;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: pop on empty, fill to capacity with extreme fields and a
    // priority tie, push into a full queue, then pop a few entries.
    send_cmd(make_cmd(OP_POP, 0, 0));
    send_cmd(make_cmd(OP_PUSH, 4095, 255));
    send_cmd(make_cmd(OP_PUSH, 0, 0));
    send_cmd(make_cmd(OP_PUSH, 4095, 0));
    for (int i = 0; i < DEPTH - 3; i++)
      send_cmd(make_cmd(OP_PUSH, 4095 - i, 128));
    send_cmd(make_cmd(OP_PUSH, 4095, 0));
    send_cmd(make_cmd(OP_POP, 4095, 255));
    send_cmd(make_cmd(OP_POP, 0, 0));
    send_cmd(make_cmd(OP_POP, 1234, 77));
    drain();

    // Random: rotate sender idling, push/pop balance and priority spread.
    per_phase = RAND_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 81;
        default: idle_pct = 18;
      endcase
      case (ph % 4)
        0:       push_pct = 75;
        1:       push_pct = 50;
        2:       push_pct = 25;
        default: push_pct = 90;
      endcase
      prio_hi = ((ph / 2) % 2 == 0) ? 255 : 3;
      for (int n = 0; n < per_phase; n++) begin
        // idle each cycle with the phase's odds before offering a command
        while ($urandom_range(99) < idle_pct) idle_for(1);
        send_cmd(random_cmd(push_pct, prio_hi));
      end
      drain();
    end

    // Let any stray strobe surface before judging.
    repeat (MAX_LAT) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Covered %0d commands: %0d pushes (%0d refused when full), %0d pops (%0d on empty).",
             sb.pushes + sb.pops, sb.pushes, sb.full_refusals, sb.pops, sb.empty_pops);
    $display("Checked %0d results; peak fill %0d of %0d, longest wait %0d, %0d errors.",
             sb.checked, sb.max_fill, DEPTH, sb.max_wait, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pqwt_pkg.sv
sv/pqwt_ram.sv
sv/priority_queue_with_wait_time_core.sv
sv/pqwt_checker.sv
bench/pqwt_tb_pkg.sv
bench/tb_top.sv
